[hw/rtl/tpicc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpicc_pkg
// Types, constants and helpers for the three-phase iir current controller.
// ----------------------------------------------------------------------------
package tpicc_pkg;

    // fixed point formats
    localparam int SAMPLE_FRAC_BITS = 12;
    localparam int COEF_FRAC_BITS   = 14;
    localparam int GAIN_FRAC_BITS   = 14;

    // field widths
    localparam int SMP_W  = 18;
    localparam int GAIN_W = 16;
    localparam int NPH    = 3;

    // multiplier operands: sample side and coefficient / gain side
    localparam int OPA_W  = SMP_W + 1;
    localparam int COEF_W = COEF_FRAC_BITS + 3;
    localparam int OPB_W  = (COEF_W > GAIN_W + 1) ? COEF_W : GAIN_W + 1;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W  = PROD_W + 3;

    // sample range limits
    localparam longint S18_MAX_L = (longint'(1) << (SMP_W - 1)) - 1;
    localparam longint S18_MIN_L = -(longint'(1) << (SMP_W - 1));
    localparam longint TEN_RAW_L = longint'(10) << SAMPLE_FRAC_BITS;
    localparam longint OUT_LIM_L = (TEN_RAW_L > S18_MAX_L) ? S18_MAX_L : TEN_RAW_L;

    localparam logic signed [ACC_W-1:0] S18_MAX = ACC_W'(S18_MAX_L);
    localparam logic signed [ACC_W-1:0] S18_MIN = ACC_W'(S18_MIN_L);
    localparam logic signed [ACC_W-1:0] OUT_LIM = ACC_W'(OUT_LIM_L);

    // iir coefficients, rounded to nearest from four decimal places
    localparam longint Q_Y1 = ((longint'(15630) << COEF_FRAC_BITS) + 5000) / 10000;
    localparam longint Q_Y2 = ((longint'(1267) << COEF_FRAC_BITS) + 5000) / 10000;
    localparam longint Q_Y3 = ((longint'(4366) << COEF_FRAC_BITS) + 5000) / 10000;
    localparam longint Q_E0 = ((longint'(2849) << COEF_FRAC_BITS) + 5000) / 10000;
    localparam longint Q_E1 = ((longint'(2615) << COEF_FRAC_BITS) + 5000) / 10000;
    localparam longint Q_E2 = ((longint'(2842) << COEF_FRAC_BITS) + 5000) / 10000;
    localparam longint Q_E3 = ((longint'(2620) << COEF_FRAC_BITS) + 5000) / 10000;

    // default damping gain, about 1.26 in Q2.14
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(20644);

    // tap codes of the iir sum
    typedef logic [2:0] t_tap;
    localparam t_tap TAP_Y1 = 3'd0;
    localparam t_tap TAP_Y2 = 3'd1;
    localparam t_tap TAP_Y3 = 3'd2;
    localparam t_tap TAP_E0 = 3'd3;
    localparam t_tap TAP_E1 = 3'd4;
    localparam t_tap TAP_E2 = 3'd5;
    localparam t_tap TAP_E3 = 3'd6;

    // phase codes
    typedef logic [1:0] t_phase;
    localparam t_phase PH_A = 2'd0;
    localparam t_phase PH_C = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_MAC,
        S_MFL,
        S_RND,
        S_DRV,
        S_DFL,
        S_DSAT,
        S_DONE
    } t_state;

    // command to the shared multiply-accumulate unit
    typedef struct packed {
        logic                    vld;
        logic                    clr;
        logic signed [OPA_W-1:0] a;
        logic signed [OPB_W-1:0] b;
    } t_mac_cmd;

    // signed coefficient of one tap
    function automatic logic signed [OPB_W-1:0] coef_of(input t_tap tap);
        logic signed [OPB_W-1:0] c;
        case (tap)
            TAP_Y1:  c = OPB_W'(Q_Y1);
            TAP_Y2:  c = OPB_W'(-Q_Y2);
            TAP_Y3:  c = OPB_W'(-Q_Y3);
            TAP_E0:  c = OPB_W'(Q_E0);
            TAP_E1:  c = OPB_W'(-Q_E1);
            TAP_E2:  c = OPB_W'(-Q_E2);
            TAP_E3:  c = OPB_W'(Q_E3);
            default: c = '0;
        endcase
        return c;
    endfunction

    // drop sh fraction bits, round to nearest with ties away from zero
    function automatic logic signed [ACC_W-1:0] round_drop(
        input logic signed [ACC_W-1:0] v,
        input int unsigned             sh
    );
        logic signed [ACC_W-1:0] half;
        logic signed [ACC_W-1:0] biased;
        half   = ACC_W'(1) <<< (sh - 1);
        biased = v + half - ACC_W'(v[ACC_W-1]);
        return biased >>> sh;
    endfunction

    // clamp to [lo, hi] and narrow to a sample
    function automatic logic signed [SMP_W-1:0] clamp_smp(
        input logic signed [ACC_W-1:0] v,
        input logic signed [ACC_W-1:0] lo,
        input logic signed [ACC_W-1:0] hi
    );
        logic signed [ACC_W-1:0] c;
        if (v < lo) begin
            c = lo;
        end else if (v > hi) begin
            c = hi;
        end else begin
            c = v;
        end
        return c[SMP_W-1:0];
    endfunction

endpackage

[hw/rtl/tpicc_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpicc_mac
// Shared two-stage multiply-accumulate unit: registered product, then add.
// ----------------------------------------------------------------------------
module tpicc_mac
    import tpicc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_cmd                i_cmd,
    output logic signed [ACC_W-1:0] o_acc
);

    logic                     r_pvld;
    logic                     r_pclr;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;

    // product stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
            r_pclr <= 1'b0;
        end else begin
            r_pvld <= i_cmd.vld;
            r_pclr <= i_cmd.clr;
        end
    end

    // product stage data
    always_ff @(posedge i_clk) begin
        r_prod <= i_cmd.a * i_cmd.b;
    end

    // accumulate stage
    always_comb begin
        n_acc = r_acc;
        if (r_pvld) begin
            n_acc = (r_pclr ? '0 : r_acc) + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

[hw/rtl/tpicc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpicc_ctrl
// Sequencer with per-phase filter history; drives the shared mac unit.
// ----------------------------------------------------------------------------
module tpicc_ctrl
    import tpicc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [SMP_W-1:0] i_tgt [NPH],
    input  logic signed [SMP_W-1:0] i_cur [NPH],
    input  logic signed [SMP_W-1:0] i_cap [NPH],
    input  logic [GAIN_W-1:0]       i_gain,
    input  logic                    i_out_free,
    output logic                    o_load,
    output logic signed [SMP_W-1:0] o_drv [NPH],
    output t_mac_cmd                o_cmd,
    input  logic signed [ACC_W-1:0] i_acc
);

    t_state r_state, n_state;
    t_phase r_ph, n_ph;
    t_tap   r_tap, n_tap;

    logic signed [SMP_W-1:0] r_tgt [NPH];
    logic signed [SMP_W-1:0] r_cur [NPH];
    logic signed [SMP_W-1:0] r_cap [NPH];
    logic signed [SMP_W-1:0] r_err, n_err;
    logic signed [SMP_W-1:0] r_u, n_u;
    logic signed [SMP_W-1:0] r_drv [NPH];
    logic signed [SMP_W-1:0] n_drv [NPH];
    logic signed [SMP_W-1:0] r_eh [NPH][3];
    logic signed [SMP_W-1:0] n_eh [NPH][3];
    logic signed [SMP_W-1:0] r_yh [NPH][3];
    logic signed [SMP_W-1:0] n_yh [NPH][3];

    logic                    take;
    logic signed [SMP_W:0]   e_diff;
    logic signed [ACC_W-1:0] e_wide;
    logic signed [SMP_W-1:0] opa;

    assign take = i_valid && o_ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= PH_A;
            r_tap   <= TAP_Y1;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_tap   <= n_tap;
        end
    end

    // filter history, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NPH; p++) begin
                for (int k = 0; k < 3; k++) begin
                    r_eh[p][k] <= '0;
                    r_yh[p][k] <= '0;
                end
            end
        end else begin
            r_eh <= n_eh;
            r_yh <= n_yh;
        end
    end

    // captured samples and working values
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_tgt <= i_tgt;
            r_cur <= i_cur;
            r_cap <= i_cap;
        end
        r_err <= n_err;
        r_u   <= n_u;
        r_drv <= n_drv;
    end

    // error of the current phase, one bit wider than a sample; it is saturated in S_ERR
    assign e_diff = {r_tgt[r_ph][SMP_W-1], r_tgt[r_ph]} - {r_cur[r_ph][SMP_W-1], r_cur[r_ph]};
    assign e_wide = ACC_W'(e_diff);

    // sample operand of each tap
    always_comb begin
        case (r_tap)
            TAP_Y1:  opa = r_yh[r_ph][0];
            TAP_Y2:  opa = r_yh[r_ph][1];
            TAP_Y3:  opa = r_yh[r_ph][2];
            TAP_E0:  opa = r_err;
            TAP_E1:  opa = r_eh[r_ph][0];
            TAP_E2:  opa = r_eh[r_ph][1];
            TAP_E3:  opa = r_eh[r_ph][2];
            default: opa = '0;
        endcase
    end

    // next state and outputs
    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_tap   = r_tap;
        n_err   = r_err;
        n_u     = r_u;
        n_drv   = r_drv;
        n_eh    = r_eh;
        n_yh    = r_yh;
        o_ready = 1'b0;
        o_load  = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = S_ERR;
                    n_ph    = PH_A;
                end
            end
            S_ERR: begin
                n_err   = clamp_smp(e_wide, S18_MIN, S18_MAX);
                n_tap   = TAP_Y1;
                n_state = S_MAC;
            end
            S_MAC: begin
                o_cmd.vld = 1'b1;
                o_cmd.clr = (r_tap == TAP_Y1);
                o_cmd.a   = OPA_W'(opa);
                o_cmd.b   = coef_of(r_tap);
                if (r_tap == TAP_E3) begin
                    n_state = S_MFL;
                end else begin
                    n_tap = r_tap + 3'd1;
                end
            end
            S_MFL: begin
                n_state = S_RND;
            end
            S_RND: begin
                n_u = clamp_smp(round_drop(i_acc, COEF_FRAC_BITS), -OUT_LIM, OUT_LIM);
                n_eh[r_ph][2] = r_eh[r_ph][1];
                n_eh[r_ph][1] = r_eh[r_ph][0];
                n_eh[r_ph][0] = r_err;
                n_yh[r_ph][2] = r_yh[r_ph][1];
                n_yh[r_ph][1] = r_yh[r_ph][0];
                n_yh[r_ph][0] = n_u;
                n_state = S_DRV;
            end
            S_DRV: begin
                o_cmd.vld = 1'b1;
                o_cmd.clr = 1'b1;
                o_cmd.a   = OPA_W'(r_u) - OPA_W'(r_cap[r_ph]);
                o_cmd.b   = OPB_W'({1'b0, i_gain});
                n_state   = S_DFL;
            end
            S_DFL: begin
                n_state = S_DSAT;
            end
            S_DSAT: begin
                n_drv[r_ph] = clamp_smp(round_drop(i_acc, GAIN_FRAC_BITS), S18_MIN, S18_MAX);
                if (r_ph == PH_C) begin
                    n_state = S_DONE;
                end else begin
                    n_ph    = r_ph + 2'd1;
                    n_state = S_ERR;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_drv = r_drv;

    // an accepted transfer starts at phase a
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (r_state == S_ERR && r_ph == PH_A))
        else $error("sequence did not start at phase a");

    // clamped controller output stays within the limit
    a_u_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRV) |-> (ACC_W'(r_u) <= OUT_LIM && ACC_W'(r_u) >= -OUT_LIM))
        else $error("controller output beyond clamp");

    // history shift stores the current error
    a_hist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RND) |=> (r_eh[r_ph][0] == $past(r_err)
                                && r_eh[r_ph][1] == $past(r_eh[r_ph][0])))
        else $error("error history shift wrong");

    // the phase index stays within three phases and the tap index within the seven taps
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_ph <= PH_C && r_tap <= TAP_E3))
        else $error("phase or tap index out of range");

endmodule

[hw/rtl/three_phase_iir_current_controller_top.sv]
`timescale 1ns / 1ps
// a new item is taken only after the previous result has gone into the output register; per phase
//   7 filter taps and one damping product go through the single shared multiplier
// the input side is ready again while a finished result still waits in the output register
// reset (synchronous, active low) clears the filter history and sets the damping gain to 1.26
// ----------------------------------------------------------------------------
// three_phase_iir_current_controller_top
// Third-order iir current controller with active capacitor-current damping.
// ----------------------------------------------------------------------------
module three_phase_iir_current_controller_top
    import tpicc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [SMP_W-1:0] i_target_a,
    input  logic signed [SMP_W-1:0] i_target_b,
    input  logic signed [SMP_W-1:0] i_target_c,
    input  logic signed [SMP_W-1:0] i_current_a,
    input  logic signed [SMP_W-1:0] i_current_b,
    input  logic signed [SMP_W-1:0] i_current_c,
    input  logic signed [SMP_W-1:0] i_cap_current_a,
    input  logic signed [SMP_W-1:0] i_cap_current_b,
    input  logic signed [SMP_W-1:0] i_cap_current_c,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [SMP_W-1:0] o_drive_a,
    output logic signed [SMP_W-1:0] o_drive_b,
    output logic signed [SMP_W-1:0] o_drive_c,
    input  logic                    i_cfg_we,
    input  logic [GAIN_W-1:0]       i_cfg_data
);

    logic [GAIN_W-1:0]       r_gain;
    logic                    r_o_valid;
    logic signed [SMP_W-1:0] r_drive [NPH];
    logic signed [SMP_W-1:0] tgt [NPH];
    logic signed [SMP_W-1:0] cur [NPH];
    logic signed [SMP_W-1:0] cap [NPH];
    logic signed [SMP_W-1:0] drv [NPH];
    logic                    out_free;
    logic                    load;
    t_mac_cmd                cmd;
    logic signed [ACC_W-1:0] acc;

    // damping gain register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_data;
        end
    end

    // gather the per-phase fields
    assign tgt = '{i_target_a, i_target_b, i_target_c};
    assign cur = '{i_current_a, i_current_b, i_current_c};
    assign cap = '{i_cap_current_a, i_cap_current_b, i_cap_current_c};

    // output register, free when empty or being taken
    assign out_free = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_drive <= drv;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_drive_a = r_drive[0];
    assign o_drive_b = r_drive[1];
    assign o_drive_c = r_drive[2];

    // sequencer and filter history
    tpicc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_tgt      (tgt),
        .i_cur      (cur),
        .i_cap      (cap),
        .i_gain     (r_gain),
        .i_out_free (out_free),
        .o_load     (load),
        .o_drv      (drv),
        .o_cmd      (cmd),
        .i_acc      (acc)
    );

    // shared multiply-accumulate unit
    tpicc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_acc   (acc)
    );

endmodule
